[src/afr_pkg.sv]
// Shared types and constants for the addressed frame receiver.
`timescale 1ns / 1ps

package afr_pkg;

  localparam int FRAME_CAPACITY_DEFAULT = 64;
  localparam int HEADER_LEN = 4;
  localparam int BYTE_W = 8;
  localparam int PARAM_INDEX_W = 6;
  localparam int STATUS_W = 2;
  localparam int OUT_DATA_W = 48;
  localparam logic [BYTE_W-1:0] NODE_ADDRESS_RESET = 8'd1;
  localparam logic [BYTE_W-1:0] BROADCAST_ADDRESS = 8'd0;

  typedef enum logic [STATUS_W-1:0] {
    ST_CONT       = 2'd0,
    ST_DONE       = 2'd1,
    ST_INVALID    = 2'd2,
    ST_NOT_FOR_US = 2'd3
  } status_t;

endpackage

[src/addressed_frame_receiver.sv]
// Byte-wise frame receiver: address filter, header latch, payload stream, XOR check.
//
//  Channel   Direction  Signals                         Contents
//  s_*       in         s_tvalid s_tready s_tdata s_tuser   rx_byte, command
//  m_*       out        m_tvalid m_tready m_tdata m_tuser   header, payload byte, status
//  cfg_*     in         cfg_wr_en cfg_wr_data              node_address
//
// Each input beat is processed in the cycle it is accepted and its result appears in the
// output register on the next cycle, so one beat per cycle is sustained while m_tready stays high.
// The frame state and the output register update together on the accepting edge.
// An input beat is taken whenever the output register is empty or is being drained.
// Reset clears the frame state, the header registers and the output valid flag, and sets
// the node address to one.
`timescale 1ns / 1ps

module addressed_frame_receiver #(
  parameter int FRAME_CAPACITY = afr_pkg::FRAME_CAPACITY_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [afr_pkg::BYTE_W-1:0]      s_tdata,     // [7:0] rx_byte
  input  logic                            s_tuser,     // [0] command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [afr_pkg::OUT_DATA_W-1:0]  m_tdata,     // [7:0] recipient, [15:8] frame_flags,
                                                        // [23:16] function_code,
                                                        // [31:24] payload_length,
                                                        // [32] param_valid,
                                                        // [38:33] param_index,
                                                        // [46:39] param_byte, [47] zero
  output logic [afr_pkg::STATUS_W-1:0]    m_tuser,     // [1:0] status
  input  logic                            cfg_wr_en,
  input  logic [afr_pkg::BYTE_W-1:0]      cfg_wr_data  // [7:0] node_address
);
  import afr_pkg::*;

  localparam int PosW = $clog2(FRAME_CAPACITY + 1);
  localparam int CmpW = (PosW > 9) ? PosW : 9;
  localparam logic [CmpW-1:0] Capacity = CmpW'(FRAME_CAPACITY);
  localparam logic [CmpW-1:0] HeaderLen = CmpW'(HEADER_LEN);

  logic [BYTE_W-1:0] node_address;
  logic [PosW-1:0]   byte_position;
  logic [BYTE_W-1:0] length_reg;
  logic [BYTE_W-1:0] running_xor;
  logic [BYTE_W-1:0] recipient_reg;
  logic [BYTE_W-1:0] flags_reg;
  logic [BYTE_W-1:0] function_reg;

  logic [PosW-1:0]   byte_position_next;
  logic [BYTE_W-1:0] length_next;
  logic [BYTE_W-1:0] running_xor_next;
  logic [BYTE_W-1:0] recipient_next;
  logic [BYTE_W-1:0] flags_next;
  logic [BYTE_W-1:0] function_next;

  logic [CmpW-1:0]   pos_ext;
  logic [CmpW-1:0]   pos_inc;
  logic [CmpW-1:0]   frame_end;
  logic [CmpW-1:0]   index_full;
  logic [BYTE_W-1:0] rx_byte;
  logic              in_accept;
  logic              foreign;
  logic              in_body;
  logic              param_valid;
  status_t           status;

  assign rx_byte   = s_tdata;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  always_comb begin
    pos_ext            = CmpW'(byte_position);
    pos_inc            = pos_ext + CmpW'(1);
    byte_position_next = byte_position;
    length_next        = length_reg;
    running_xor_next   = running_xor;
    recipient_next     = recipient_reg;
    flags_next         = flags_reg;
    function_next      = function_reg;
    param_valid        = 1'b0;
    status             = ST_CONT;
    foreign            = (pos_ext == '0) && (rx_byte != BROADCAST_ADDRESS)
                         && (rx_byte != node_address);
    if (pos_ext == CmpW'(3)) begin
      length_next = rx_byte;
    end
    frame_end  = HeaderLen + CmpW'(length_next);
    in_body    = pos_ext < frame_end;
    index_full = pos_ext - HeaderLen;
    priority if (s_tuser) begin
      byte_position_next = '0;
      length_next        = '0;
      running_xor_next   = '0;
      status             = ST_CONT;
    end else if (pos_ext >= Capacity) begin
      length_next = length_reg;
      status      = ST_INVALID;
    end else if (foreign) begin
      length_next = length_reg;
      status      = ST_NOT_FOR_US;
    end else begin
      unique case (pos_ext)
        CmpW'(0): recipient_next = rx_byte;
        CmpW'(1): flags_next     = rx_byte;
        CmpW'(2): function_next  = rx_byte;
        default: ;
      endcase
      if (in_body) begin
        running_xor_next = running_xor ^ rx_byte;
      end
      param_valid        = in_body && (pos_ext >= HeaderLen);
      byte_position_next = PosW'(pos_inc);
      priority if (pos_inc >= Capacity) begin
        status = ST_INVALID;
      end else if (pos_inc > frame_end) begin
        status = (running_xor_next == rx_byte) ? ST_DONE : ST_INVALID;
      end else begin
        status = ST_CONT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address  <= NODE_ADDRESS_RESET;
      byte_position <= '0;
      length_reg    <= '0;
      running_xor   <= '0;
      recipient_reg <= '0;
      flags_reg     <= '0;
      function_reg  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_address <= cfg_wr_data;
      end
      if (in_accept) begin
        byte_position <= byte_position_next;
        length_reg    <= length_next;
        running_xor   <= running_xor_next;
        recipient_reg <= recipient_next;
        flags_reg     <= flags_next;
        function_reg  <= function_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_tuser <= status;
      m_tdata <= {1'b0,
                  param_valid ? rx_byte : {BYTE_W{1'b0}},
                  param_valid ? index_full[PARAM_INDEX_W-1:0] : {PARAM_INDEX_W{1'b0}},
                  param_valid,
                  length_next, function_next, flags_next, recipient_next};
    end
  end

  a_position_bounded: assert property (@(posedge clk) disable iff (rst)
    CmpW'(byte_position) <= Capacity)
    else $error("byte position beyond frame capacity");

  a_payload_not_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> (m_tuser == ST_CONT) || (m_tuser == ST_INVALID))
    else $error("payload beat reported as done or foreign");

  a_reset_command: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_tuser |=> (byte_position == '0) && m_tvalid && (m_tuser == ST_CONT)
      && !m_tdata[32])
    else $error("reset command did not restart the frame");

  a_foreign_dropped: assert property (@(posedge clk) disable iff (rst)
    in_accept && !s_tuser && foreign && (byte_position == '0)
      |=> (byte_position == '0) && (m_tuser == ST_NOT_FOR_US))
    else $error("foreign frame start changed state");

endmodule
